// ===== rtl/tdt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared types, codes and helpers for the time dependency tracker.
// ----------------------------------------------------------------------------
package tdt_pkg;

    localparam int ID_W        = 31;
    localparam int TIME_W      = 32;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_SETUP  = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_WAIT   = 2'd2,
        CMD_OFFSET = 2'd3
    } tdt_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2
    } tdt_status_t;

    typedef struct packed {
        logic start;
        logic sweep;
        logic commit;
    } tdt_ctrl_t;

    typedef struct packed {
        logic sweep_done;
    } tdt_stat_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

// ===== rtl/tdt_cmd_if.sv =====
// ----------------------------------------------------------------------------
// tdt_cmd_if
// Command channel: valid/ready handshake with one command word.
// ----------------------------------------------------------------------------
interface tdt_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [30:0] source_id;
    logic [31:0] time_value;
    logic [31:0] step_size;

    modport source (output valid, command, source_id, time_value, step_size,
                    input ready);
    modport sink   (input valid, command, source_id, time_value, step_size,
                    output ready);
endinterface

// ===== rtl/tdt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tdt_rsp_if
// Response channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface tdt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        proceed;
    logic        released;
    logic [31:0] min_time;
    logic [6:0]  entry_count;

    modport source (output valid, status, proceed, released, min_time, entry_count,
                    input ready);
    modport sink   (input valid, status, proceed, released, min_time, entry_count,
                    output ready);
endinterface

// ===== rtl/tdt_ram.sv =====
// ----------------------------------------------------------------------------
// tdt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/tdt_datapath.sv =====
// ----------------------------------------------------------------------------
// tdt_datapath
// Source table sweep: id match, time update, running minimum, fill count,
// pending wait and result word.
// ----------------------------------------------------------------------------
module tdt_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tdt_pkg::tdt_ctrl_t ctrl,
    output tdt_pkg::tdt_stat_t stat,
    input  logic [1:0]        command,
    input  logic [30:0]       source_id,
    input  logic [31:0]       time_value,
    input  logic [31:0]       step_size,
    output logic [1:0]        status,
    output logic              proceed,
    output logic              released,
    output logic [31:0]       min_time,
    output logic [6:0]        entry_count
);
    import tdt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = ID_W + TIME_W;

    tdt_cmd_t            cmd_reg;
    logic [ID_W-1:0]     id_reg;
    logic [TIME_W-1:0]   tv_reg;
    logic [TIME_W-1:0]   dt_reg;
    logic [CW-1:0]       rd_idx_reg;
    logic                rd_vld_reg;
    logic [AW-1:0]       wr_idx_reg;
    logic [TIME_W-1:0]   min_reg;
    logic                found_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [TIME_W-1:0]   pending_reg;
    logic [TIME_W-1:0]   pending_next;

    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                proceed_reg;
    logic                proceed_next;
    logic                released_reg;
    logic                released_next;
    logic [TIME_W-1:0]   min_out_reg;
    logic [TIME_W-1:0]   min_out_next;
    logic [COUNT_OUT_W-1:0] count_out_reg;
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [EW-1:0]       ram_wdata;
    logic [EW-1:0]       ram_rdata;
    logic [ID_W-1:0]     rd_id;
    logic [TIME_W-1:0]   rd_time;
    logic [TIME_W-1:0]   new_time;
    logic                issue;
    logic                match;
    logic                empty;
    logic                full;
    logic                insert;
    logic [TIME_W-1:0]   acc_min;
    logic [TIME_W-1:0]   target;

    tdt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_id   = ram_rdata[EW-1:TIME_W];
    assign rd_time = ram_rdata[TIME_W-1:0];
    assign issue   = ctrl.sweep && (rd_idx_reg < count_reg);
    assign match   = (rd_id == id_reg);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(TABLE_DEPTH));
    assign insert  = (cmd_reg == CMD_SETUP) && !found_reg && !full;
    assign acc_min = empty ? '0 : min_reg;
    assign target  = sat_add(tv_reg, dt_reg);

    assign stat.sweep_done = (rd_idx_reg == count_reg) && !rd_vld_reg;

    always_comb
    begin
        case (cmd_reg)
            CMD_SETUP, CMD_UPDATE:
            begin
                new_time = (match && (tv_reg > rd_time)) ? tv_reg : rd_time;
            end
            CMD_OFFSET:
            begin
                new_time = sat_add(rd_time, tv_reg);
            end
            default:
            begin
                new_time = rd_time;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wr_idx_reg;
        ram_wdata = {rd_id, new_time};
        if (rd_vld_reg)
        begin
            ram_we = 1'b1;
        end
        else if (ctrl.commit && insert)
        begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[AW-1:0];
            ram_wdata = {id_reg, tv_reg};
        end
    end

    always_comb
    begin
        status_next   = ST_OK;
        proceed_next  = 1'b0;
        released_next = 1'b0;
        min_out_next  = acc_min;
        pending_next  = pending_reg;
        count_next    = count_reg;
        case (cmd_reg)
            CMD_SETUP:
            begin
                if (insert)
                begin
                    count_next   = count_reg + CW'(1);
                    min_out_next = (tv_reg < min_reg) ? tv_reg : min_reg;
                end
                else if (!found_reg)
                begin
                    status_next = ST_FULL;
                end
            end
            CMD_UPDATE:
            begin
                if (!found_reg)
                begin
                    status_next = ST_UNKNOWN;
                end
                else if ((pending_reg != '0) && (min_reg >= pending_reg))
                begin
                    pending_next  = '0;
                    released_next = 1'b1;
                end
            end
            CMD_WAIT:
            begin
                if (empty || (min_reg >= target))
                begin
                    proceed_next = 1'b1;
                end
                else
                begin
                    pending_next = target;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
            count_reg   <= '0;
            pending_reg <= '0;
        end
        else
        begin
            rd_vld_reg <= issue;
            if (ctrl.start)
            begin
                rd_idx_reg <= '0;
                found_reg  <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + CW'(1);
                end
                if (rd_vld_reg && match)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (ctrl.commit)
            begin
                count_reg   <= count_next;
                pending_reg <= pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            cmd_reg <= tdt_cmd_t'(command);
            id_reg  <= source_id;
            tv_reg  <= time_value;
            dt_reg  <= step_size;
            min_reg <= {TIME_W{1'b1}};
        end
        else if (rd_vld_reg && (new_time < min_reg))
        begin
            min_reg <= new_time;
        end
        if (issue)
        begin
            wr_idx_reg <= rd_idx_reg[AW-1:0];
        end
        if (ctrl.commit)
        begin
            status_reg    <= status_next;
            proceed_reg   <= proceed_next;
            released_reg  <= released_next;
            min_out_reg   <= min_out_next;
            count_out_reg <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign status      = status_reg;
    assign proceed     = proceed_reg;
    assign released    = released_reg;
    assign min_time    = min_out_reg;
    assign entry_count = count_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_read_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (CW'(wr_idx_reg) < count_reg))
        else $error("read of entry beyond fill count");

    a_count_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.commit |=> $stable(count_reg))
        else $error("fill count changed outside commit");

endmodule

// ===== rtl/tdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdt_ctrl
// Command sequencer: accept a word, run the table sweep, commit the result
// into the output register.
// ----------------------------------------------------------------------------
module tdt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  tdt_pkg::tdt_stat_t stat,
    output tdt_pkg::tdt_ctrl_t ctrl
);
    import tdt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SWEEP  = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign cmd_ready   = (state_reg == S_IDLE);
    assign ctrl.start  = cmd_valid && cmd_ready;
    assign ctrl.sweep  = (state_reg == S_SWEEP);
    assign ctrl.commit = (state_reg == S_FINISH) && (!out_valid_reg || rsp_ready);
    assign rsp_valid   = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (stat.sweep_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (ctrl.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_start_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> (state_reg == S_SWEEP))
        else $error("accepted word did not start a sweep");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp_ready) |-> !ctrl.commit)
        else $error("result overwritten while stalled");

endmodule

// ===== rtl/time_dependency_tracker_top.sv =====
// ----------------------------------------------------------------------------
// time_dependency_tracker_top
// A command word is accepted in idle, the sweep state reads each held entry, and
// the finish state commits the result into the response register, waiting
// there while the previous word has not left.
// A new command word is taken only after the last result is committed; the
// table RAM is swept one entry per cycle through its single read port.
// Reset clears the fill count, the pending wait and both handshakes; table
// contents are not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module time_dependency_tracker_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    tdt_cmd_if.sink    cmd,
    tdt_rsp_if.source  rsp
);
    import tdt_pkg::*;

    tdt_ctrl_t ctrl;
    tdt_stat_t stat;

    tdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    tdt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .command     (cmd.command),
        .source_id   (cmd.source_id),
        .time_value  (cmd.time_value),
        .step_size   (cmd.step_size),
        .status      (rsp.status),
        .proceed     (rsp.proceed),
        .released    (rsp.released),
        .min_time    (rsp.min_time),
        .entry_count (rsp.entry_count)
    );
endmodule

// ===== sim/time_dependency_tracker_top_tb.sv =====
// ----------------------------------------------------------------------------
// time_dependency_tracker_top_tb
// Self-checking bench for the time dependency tracker. A queue-fed driver
// offers command words and a monitor checks every response word against a
// behavioral copy of the source table, the pending wait and saturating time
// math. The run starts from an empty table and grows it to full through
// update/release rounds with noise mixed in. It steps through four handshake
// phases and holds off the response side once. It ends with saturation.
// ----------------------------------------------------------------------------
module time_dependency_tracker_top_tb;
    import tdt_pkg::*;

    localparam int DEPTH       = 64;
    localparam int PHASE_ITEMS = 425;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT[4]  = '{0, 66, 0, 32};
    localparam int STALL_PCT[4] = '{0, 0, 66, 32};

    typedef struct {
        tdt_cmd_t          op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] dt;
    } command_word_t;

    typedef struct {
        tdt_status_t             status;
        logic                    proceed;
        logic                    released;
        logic [TIME_W-1:0]       min_time;
        logic [COUNT_OUT_W-1:0]  entry_count;
    } tracker_response_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tdt_cmd_if cmd_bus ();
    tdt_rsp_if rsp_bus ();

    time_dependency_tracker_top #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    always #5 clk = ~clk;

    // behavioral table
    logic [ID_W-1:0]   slot_id   [DEPTH];
    logic [TIME_W-1:0] slot_time [DEPTH];
    bit                slot_used [DEPTH];
    logic [TIME_W-1:0] wait_target = '0;

    command_word_t     pending_words[$];
    tracker_response_t awaited_responses[$];
    logic [ID_W-1:0]   roster[$];
    logic [TIME_W-1:0] base_time = '0;

    int idle_pct = 0;
    int stall_pct = 0;
    logic holding = 1'b0;
    int items_queued = 0;
    int results_checked = 0;
    int mismatches = 0;
    int releases_seen = 0;
    int proceeds_seen = 0;
    int unknown_seen = 0;
    int full_seen = 0;

    function automatic logic [TIME_W-1:0] clamp_sum(logic [TIME_W-1:0] a,
                                                    logic [TIME_W-1:0] b);
        return (a > 32'hFFFF_FFFF - b) ? 32'hFFFF_FFFF : a + b;
    endfunction

    function automatic int lookup_slot(logic [ID_W-1:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (slot_used[i] && slot_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic logic [TIME_W-1:0] table_min();
        logic [TIME_W-1:0] m;
        bit any;
        m = '1;
        any = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            if (slot_used[i])
            begin
                any = 1'b1;
                if (slot_time[i] < m)
                    m = slot_time[i];
            end
        return any ? m : '0;
    endfunction

    function automatic logic [COUNT_OUT_W-1:0] table_count();
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            if (slot_used[i])
                n++;
        return COUNT_OUT_W'(n);
    endfunction

    function automatic tracker_response_t expected_response(command_word_t w);
        tracker_response_t r;
        int slot;
        int free_slot;
        logic [TIME_W-1:0] target;
        r.status = ST_OK;
        r.proceed = 1'b0;
        r.released = 1'b0;
        case (w.op)
            CMD_SETUP:
            begin
                slot = lookup_slot(w.id);
                if (slot >= 0)
                begin
                    if (w.t > slot_time[slot])
                        slot_time[slot] = w.t;
                end
                else
                begin
                    free_slot = -1;
                    for (int i = DEPTH - 1; i >= 0; i--)
                        if (!slot_used[i])
                            free_slot = i;
                    if (free_slot < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        slot_used[free_slot] = 1'b1;
                        slot_id[free_slot] = w.id;
                        slot_time[free_slot] = w.t;
                    end
                end
            end
            CMD_UPDATE:
            begin
                slot = lookup_slot(w.id);
                if (slot < 0)
                    r.status = ST_UNKNOWN;
                else
                begin
                    if (slot_time[slot] < w.t)
                        slot_time[slot] = w.t;
                    if (wait_target != 0 && table_min() >= wait_target)
                    begin
                        wait_target = '0;
                        r.released = 1'b1;
                    end
                end
            end
            CMD_WAIT:
            begin
                target = clamp_sum(w.t, w.dt);
                if (table_count() == 0 || table_min() >= target)
                    r.proceed = 1'b1;
                else
                    wait_target = target;
            end
            default:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (slot_used[i])
                        slot_time[i] = clamp_sum(slot_time[i], w.t);
            end
        endcase
        r.min_time = table_min();
        r.entry_count = table_count();
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("mismatch on %s at response %0d: got 0x%08h, expected 0x%08h",
                 field, results_checked, got, want);
    endtask

    // stimulus helpers
    function automatic bit on_roster(logic [ID_W-1:0] id);
        foreach (roster[i])
            if (roster[i] == id)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [ID_W-1:0] fresh_id();
        logic [ID_W-1:0] id;
        do
            id = ID_W'($urandom());
        while (on_roster(id));
        return id;
    endfunction

    function automatic logic [ID_W-1:0] known_id();
        return roster[$urandom_range(0, roster.size() - 1)];
    endfunction

    function automatic void queue_word(tdt_cmd_t op, logic [ID_W-1:0] id,
                                       logic [TIME_W-1:0] t, logic [TIME_W-1:0] dt);
        command_word_t w;
        w.op = op;
        w.id = id;
        w.t = t;
        w.dt = dt;
        pending_words.push_back(w);
        items_queued++;
        if (op == CMD_SETUP && roster.size() < DEPTH && !on_roster(id))
            roster.push_back(id);
    endfunction

    function automatic void queue_noise(logic [TIME_W-1:0] floor_time);
        logic [TIME_W-1:0] t;
        case ($urandom_range(0, 7))
            0: queue_word(CMD_SETUP, fresh_id(), base_time + $urandom_range(0, 3000), '0);
            1: queue_word(CMD_SETUP, known_id(), base_time + $urandom_range(0, 3000),
                          $urandom());
            2: queue_word(CMD_UPDATE, fresh_id(), $urandom(), $urandom());
            3:
            begin
                t = $urandom_range(0, floor_time);
                queue_word(CMD_WAIT, known_id(), t, $urandom_range(0, floor_time - t));
            end
            4: queue_word(CMD_WAIT, fresh_id(), $urandom(), $urandom());
            5: queue_word(CMD_OFFSET, fresh_id(), $urandom_range(0, 255), $urandom());
            6: queue_word(CMD_SETUP, known_id(), $urandom(), '0);
            default: queue_word(CMD_UPDATE, known_id(), base_time + $urandom_range(0, 2000),
                                '0);
        endcase
    endfunction

    // one wait, then updates to every source (a shuffled prefix in some rounds) so the last one can free it
    function automatic void queue_round();
        logic [TIME_W-1:0] floor_time;
        logic [TIME_W-1:0] target;
        logic [TIME_W-1:0] dt;
        logic [ID_W-1:0] order[$];
        logic [ID_W-1:0] tmp;
        int j;
        int cut;
        floor_time = base_time;
        base_time = base_time + $urandom_range(1, 1000);
        repeat ($urandom_range(0, 3))
            queue_word(CMD_SETUP, fresh_id(), base_time + $urandom_range(0, 3000), '0);
        target = base_time + $urandom_range(0, 500);
        dt = $urandom_range(0, target);
        queue_word(CMD_WAIT, known_id(), target - dt, dt);
        order = roster;
        for (int i = order.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, order.size()) : order.size();
        for (int i = 0; i < cut; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                queue_noise(floor_time);
            if ($urandom_range(0, 9) == 0)
                queue_word(CMD_UPDATE, order[i], $urandom_range(floor_time, target), '0);
            else
                queue_word(CMD_UPDATE, order[i], target + $urandom_range(0, 2000), '0);
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        command_word_t w;
        if (!rst_n)
            cmd_bus.valid <= 1'b0;
        else if (!cmd_bus.valid || cmd_bus.ready)
        begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                w = pending_words.pop_front();
                cmd_bus.valid      <= 1'b1;
                cmd_bus.command    <= w.op;
                cmd_bus.source_id  <= w.id;
                cmd_bus.time_value <= w.t;
                cmd_bus.step_size  <= w.dt;
            end
            else
                cmd_bus.valid <= 1'b0;
        end
    end

    // response side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else
            rsp_bus.ready <= !holding && ($urandom_range(0, 99) >= stall_pct);
    end

    // monitor: check first, then predict the word accepted at this edge
    always @(posedge clk)
    begin
        tracker_response_t want;
        command_word_t w;
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                results_checked++;
                if (awaited_responses.size() == 0)
                    report_mismatch("unexpected word", rsp_bus.min_time, '0);
                else
                begin
                    want = awaited_responses.pop_front();
                    if (rsp_bus.status !== want.status)
                        report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
                    if (rsp_bus.proceed !== want.proceed)
                        report_mismatch("proceed", 32'(rsp_bus.proceed), 32'(want.proceed));
                    if (rsp_bus.released !== want.released)
                        report_mismatch("released", 32'(rsp_bus.released),
                                        32'(want.released));
                    if (rsp_bus.min_time !== want.min_time)
                        report_mismatch("min_time", rsp_bus.min_time, want.min_time);
                    if (rsp_bus.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(rsp_bus.entry_count),
                                        32'(want.entry_count));
                    releases_seen += want.released;
                    proceeds_seen += want.proceed;
                    unknown_seen += (want.status == ST_UNKNOWN);
                    full_seen += (want.status == ST_FULL);
                end
            end
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                w.op = tdt_cmd_t'(cmd_bus.command);
                w.id = cmd_bus.source_id;
                w.t = cmd_bus.time_value;
                w.dt = cmd_bus.step_size;
                awaited_responses.push_back(expected_response(w));
            end
        end
    end

    // long hold-off on the response side to back up the command side
    initial
    begin
        wait (results_checked >= 60);
        @(posedge clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d of %0d words answered", results_checked, items_queued);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int start;
        cmd_bus.valid = 1'b0;
        cmd_bus.command = CMD_SETUP;
        cmd_bus.source_id = '0;
        cmd_bus.time_value = '0;
        cmd_bus.step_size = '0;
        rsp_bus.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < 4; p++)
        begin
            while (results_checked < items_queued)
                @(posedge clk);
            @(posedge clk);
            idle_pct <= IDLE_PCT[p];
            stall_pct <= STALL_PCT[p];
            if (p == 0)
            begin
                queue_word(CMD_WAIT, '0, 32'd7, 32'd3);
                queue_word(CMD_UPDATE, 31'h7FFF_FFFF, 32'd9, '0);
                queue_word(CMD_OFFSET, '0, 32'h0000_1234, '0);
                queue_word(CMD_SETUP, '0, 32'd100, '0);
                queue_word(CMD_SETUP, 31'h7FFF_FFFF, 32'd50, '0);
                queue_word(CMD_SETUP, '0, 32'd20, '0);
                queue_word(CMD_SETUP, '0, 32'd200, '0);
                queue_word(CMD_WAIT, '0, '0, '0);
                queue_word(CMD_WAIT, '0, 32'd30, 32'd20);
                queue_word(CMD_WAIT, '0, 32'd100, 32'd60);
                queue_word(CMD_WAIT, '0, 32'd40, 32'd5);
                queue_word(CMD_SETUP, 31'h7FFF_FFFF, 32'd300, '0);
                queue_word(CMD_UPDATE, 31'h2AAA_AAAA, 32'd500, '0);
                queue_word(CMD_OFFSET, '0, 32'd1, '0);
                queue_word(CMD_UPDATE, '0, 32'd10, '0);
                queue_word(CMD_UPDATE, '0, 32'd400, '0);
                queue_word(CMD_WAIT, '0, 32'h8000_0000, 32'h8000_0000);
                queue_word(CMD_UPDATE, 31'h7FFF_FFFF, 32'h5555_5555, '0);
                queue_word(CMD_SETUP, 31'h5555_5555, 32'd1000, '0);
                queue_word(CMD_WAIT, '0, 32'd250, 32'd250);
                queue_word(CMD_UPDATE, '0, 32'd600, '0);
                base_time = 32'd1000;
            end
            start = items_queued;
            while (items_queued - start < PHASE_ITEMS)
                queue_round();
            if (p == 3)
            begin
                // fill the table, overflow it, then drive every time to the top
                while (roster.size() < DEPTH)
                    queue_word(CMD_SETUP, fresh_id(), base_time + $urandom_range(0, 100), '0);
                queue_word(CMD_SETUP, fresh_id(), 32'hFFFF_FFFF, '0);
                queue_word(CMD_SETUP, fresh_id(), '0, '0);
                queue_word(CMD_WAIT, '0, base_time, 32'd100_000);
                queue_word(CMD_OFFSET, '0, 32'hFFFF_FFFF, '0);
                queue_word(CMD_SETUP, known_id(), 32'd5, '0);
                queue_word(CMD_UPDATE, known_id(), '0, '0);
                queue_word(CMD_WAIT, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                queue_word(CMD_WAIT, '0, '0, '0);
                queue_word(CMD_UPDATE, fresh_id(), 32'hFFFF_FFFF, '0);
            end
        end

        while (results_checked < items_queued)
            @(posedge clk);
        repeat (DEPTH + 16) @(posedge clk);
        if (awaited_responses.size() != 0)
            report_mismatch("missing words", 32'(awaited_responses.size()), '0);

        $display("ran %0d command words through four handshake phases, %0d releases, %0d proceeds",
                 items_queued, releases_seen, proceeds_seen);
        $display("%0d updates of unknown sources, %0d inserts into a full table, %0d mismatches",
                 unknown_seen, full_seen, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
